// ----- sv/assert_macros.svh -----
// Assertion macros for the top-level unit, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk_i.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk_i.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tvew_pkg.sv -----
`timescale 1ns / 1ps
package tvew_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int BETA_W     = 48;
  localparam int FRAC       = 40;
  // Sum of two squared differences.
  localparam int P_W        = 2 * PIXEL_BITS + 1;
  // P scaled by 2^40 plus beta.
  localparam int S_W        = P_W + FRAC + 1;
  // Remainder 2^80 - w^2 * S.
  localparam int R_W        = 2 * FRAC + 1;
  // Running product w * S, bounded by 2^40 * sqrt(S).
  localparam int Q_W        = FRAC + (S_W + 1) / 2 + 1;
  localparam int W_W        = FRAC + 1;
  // Trial term before it is compared with the remainder.
  localparam int T_W        = S_W + 2 * FRAC + 2;
  localparam int N_ITER     = W_W;
  localparam int B_W        = $clog2(N_ITER);
  localparam int N_LANE     = 4;
  localparam int SUM_W      = W_W + 2;

  localparam logic [W_W-1:0]  WEIGHT_MAX = W_W'(1) << FRAC;
  localparam logic [BETA_W-1:0] BETA_RST = BETA_W'(1);

  // Lane order inside a stage.
  localparam int LANE_UP    = 0;
  localparam int LANE_LEFT  = 1;
  localparam int LANE_RIGHT = 2;
  localparam int LANE_DOWN  = 3;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix_center;
    logic [PIXEL_BITS-1:0] pix_up;
    logic [PIXEL_BITS-1:0] pix_up_left;
    logic [PIXEL_BITS-1:0] pix_left;
    logic [PIXEL_BITS-1:0] pix_right;
    logic [PIXEL_BITS-1:0] pix_down;
    logic                  at_top;
    logic                  at_left;
    logic                  at_right;
    logic                  at_bottom;
  } in_item_t;

  typedef struct packed {
    logic           act;
    logic [R_W-1:0] rem;
    logic [Q_W-1:0] q;
    logic [S_W-1:0] s;
    logic [W_W-1:0] w;
  } lane_t;

  typedef struct packed {
    logic                     valid;
    lane_t [N_LANE-1:0]       lane;
  } stage_t;

endpackage

// ----- sv/tvew_in_if.sv -----
`timescale 1ns / 1ps
interface tvew_in_if;
  logic                            valid;
  logic                            ready;
  logic [tvew_pkg::PIXEL_BITS-1:0] pix_center;
  logic [tvew_pkg::PIXEL_BITS-1:0] pix_up;
  logic [tvew_pkg::PIXEL_BITS-1:0] pix_up_left;
  logic [tvew_pkg::PIXEL_BITS-1:0] pix_left;
  logic [tvew_pkg::PIXEL_BITS-1:0] pix_right;
  logic [tvew_pkg::PIXEL_BITS-1:0] pix_down;
  logic                            at_top;
  logic                            at_left;
  logic                            at_right;
  logic                            at_bottom;

  modport source (output valid, pix_center, pix_up, pix_up_left, pix_left, pix_right,
                  pix_down, at_top, at_left, at_right, at_bottom, input ready);
  modport sink (input valid, pix_center, pix_up, pix_up_left, pix_left, pix_right,
                pix_down, at_top, at_left, at_right, at_bottom, output ready);
endinterface

// ----- sv/tvew_out_if.sv -----
`timescale 1ns / 1ps
interface tvew_out_if;
  logic                         valid;
  logic                         ready;
  logic [tvew_pkg::W_W-1:0]     weight_up;
  logic [tvew_pkg::W_W-1:0]     weight_left;
  logic [tvew_pkg::W_W-1:0]     weight_right;
  logic [tvew_pkg::W_W-1:0]     weight_down;
  logic [tvew_pkg::SUM_W-1:0]   weight_sum;

  modport source (output valid, weight_up, weight_left, weight_right, weight_down,
                  weight_sum, input ready);
  modport sink (input valid, weight_up, weight_left, weight_right, weight_down,
                weight_sum, output ready);
endinterface

// ----- sv/tvew_cfg_if.sv -----
`timescale 1ns / 1ps
interface tvew_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tvew_pkg::BETA_W-1:0]   beta_q40;

  modport source (output valid, beta_q40, input ready);
  modport sink (input valid, beta_q40, output ready);
endinterface

// ----- sv/tvew_prep.sv -----
`timescale 1ns / 1ps
module tvew_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  tvew_pkg::in_item_t            item_i,
  input  logic [tvew_pkg::BETA_W-1:0]   beta_i,
  output tvew_pkg::stage_t              stage_o
);

  logic [tvew_pkg::PIXEL_BITS-1:0] dx [tvew_pkg::N_LANE];
  logic [tvew_pkg::PIXEL_BITS-1:0] dy [tvew_pkg::N_LANE];
  logic [tvew_pkg::N_LANE-1:0]     act;
  logic [tvew_pkg::PIXEL_BITS-1:0] d_up_ul, d_c_up, d_c_lf, d_lf_ul, d_c_rt, d_c_dn;
  tvew_pkg::stage_t                stage_d;
  logic                            valid_q;
  tvew_pkg::lane_t [tvew_pkg::N_LANE-1:0] lane_q;

  function automatic logic [tvew_pkg::PIXEL_BITS-1:0] absd(
    input logic [tvew_pkg::PIXEL_BITS-1:0] a,
    input logic [tvew_pkg::PIXEL_BITS-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Differences of the mixed pairs; terms over absent pixels are zero.
  always_comb begin
    d_up_ul = absd(item_i.pix_up, item_i.pix_up_left);
    d_c_up  = absd(item_i.pix_center, item_i.pix_up);
    d_c_lf  = absd(item_i.pix_center, item_i.pix_left);
    d_lf_ul = absd(item_i.pix_left, item_i.pix_up_left);
    d_c_rt  = absd(item_i.pix_center, item_i.pix_right);
    d_c_dn  = absd(item_i.pix_center, item_i.pix_down);

    dx[tvew_pkg::LANE_UP]    = item_i.at_left ? '0 : d_up_ul;
    dy[tvew_pkg::LANE_UP]    = d_c_up;
    dx[tvew_pkg::LANE_LEFT]  = d_c_lf;
    dy[tvew_pkg::LANE_LEFT]  = item_i.at_top ? '0 : d_lf_ul;
    dx[tvew_pkg::LANE_RIGHT] = d_c_rt;
    dy[tvew_pkg::LANE_RIGHT] = item_i.at_top ? '0 : d_c_up;
    dx[tvew_pkg::LANE_DOWN]  = item_i.at_left ? '0 : d_c_lf;
    dy[tvew_pkg::LANE_DOWN]  = d_c_dn;

    act[tvew_pkg::LANE_UP]    = !item_i.at_top;
    act[tvew_pkg::LANE_LEFT]  = !item_i.at_left;
    act[tvew_pkg::LANE_RIGHT] = !item_i.at_right;
    act[tvew_pkg::LANE_DOWN]  = !item_i.at_bottom;
  end

  // Squared sum, scaled radicand and the start values of the root search.
  always_comb begin
    stage_d.valid = valid_i;
    for (int l = 0; l < tvew_pkg::N_LANE; l++) begin
      stage_d.lane[l].act = act[l];
      stage_d.lane[l].s   = {(tvew_pkg::P_W)'({dx[l]} * {dx[l]}) +
                             (tvew_pkg::P_W)'({dy[l]} * {dy[l]}),
                             (tvew_pkg::FRAC)'(0)} + tvew_pkg::S_W'(beta_i);
      stage_d.lane[l].rem = tvew_pkg::R_W'(1) << (2 * tvew_pkg::FRAC);
      stage_d.lane[l].q   = '0;
      stage_d.lane[l].w   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= stage_d.lane;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.lane  = lane_q;

endmodule

// ----- sv/tvew_isqrt_stage.sv -----
`timescale 1ns / 1ps
module tvew_isqrt_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [tvew_pkg::B_W-1:0]   bit_i,
  input  tvew_pkg::stage_t           stage_i,
  output tvew_pkg::stage_t           stage_o
);

  logic [tvew_pkg::T_W-1:0] trial [tvew_pkg::N_LANE];
  logic [tvew_pkg::T_W-1:0] s_sh  [tvew_pkg::N_LANE];
  tvew_pkg::stage_t         stage_d;
  logic                     valid_q;
  tvew_pkg::lane_t [tvew_pkg::N_LANE-1:0] lane_q;

  // One bit of w per stage: accept 2^b when (w + 2^b)^2 * S still fits 2^80.
  // Growth of w^2 * S is 2^(b+1) * w * S + 2^(2b) * S, kept as a remainder.
  always_comb begin
    stage_d = stage_i;
    for (int l = 0; l < tvew_pkg::N_LANE; l++) begin
      s_sh[l]  = tvew_pkg::T_W'(stage_i.lane[l].s) << bit_i;
      trial[l] = (tvew_pkg::T_W'(stage_i.lane[l].q) << ({1'b0, bit_i} + 1'b1)) +
                 (tvew_pkg::T_W'(stage_i.lane[l].s) << {bit_i, 1'b0});
      if (trial[l] <= tvew_pkg::T_W'(stage_i.lane[l].rem)) begin
        stage_d.lane[l].rem = stage_i.lane[l].rem - trial[l][tvew_pkg::R_W-1:0];
        stage_d.lane[l].q   = stage_i.lane[l].q + s_sh[l][tvew_pkg::Q_W-1:0];
        stage_d.lane[l].w   = stage_i.lane[l].w | (tvew_pkg::W_W'(1) << bit_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= stage_d.lane;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.lane  = lane_q;

endmodule

// ----- sv/tvew_finish.sv -----
`timescale 1ns / 1ps
module tvew_finish (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  tvew_pkg::stage_t             stage_i,
  output logic                         valid_o,
  output logic [tvew_pkg::W_W-1:0]     weight_o [tvew_pkg::N_LANE],
  output logic [tvew_pkg::SUM_W-1:0]   sum_o
);

  logic [tvew_pkg::W_W-1:0]   wt_d [tvew_pkg::N_LANE];
  logic [tvew_pkg::W_W-1:0]   wt_q [tvew_pkg::N_LANE];
  logic [tvew_pkg::SUM_W-1:0] sum_d, sum_q;
  logic                       valid_q;

  // Saturate, zero the missing neighbours, and add up the diagonal entry.
  always_comb begin
    sum_d = '0;
    for (int l = 0; l < tvew_pkg::N_LANE; l++) begin
      if (!stage_i.lane[l].act) begin
        wt_d[l] = '0;
      end else if (stage_i.lane[l].w > tvew_pkg::WEIGHT_MAX) begin
        wt_d[l] = tvew_pkg::WEIGHT_MAX;
      end else begin
        wt_d[l] = stage_i.lane[l].w;
      end
      sum_d = sum_d + tvew_pkg::SUM_W'(wt_d[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wt_q  <= wt_d;
      sum_q <= sum_d;
    end
  end

  assign valid_o  = valid_q;
  assign weight_o = wt_q;
  assign sum_o    = sum_q;

endmodule

// ----- sv/tv_edge_weight_stencil_unit.sv -----
// Channel   Role   Handshake       Carries
// in_i      sink   valid / ready   six neighbourhood pixels and four border flags
// out_o     source valid / ready   four Q1.40 weights and their sum
// cfg_i     sink   valid / ready   beta_q40, always ready
//
// One item enters per cycle while out_o is not stalled; a result is registered through the
// prep stage, the root-search stages and the finish stage (43 register stages in all).
// The inverse square root settles one weight bit per stage.
// Reset clears the stage valid bits and sets beta_q40 to 1.
// The whole pipeline holds while a result waits on out_o; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tv_edge_weight_stencil_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  tvew_in_if.sink      in_i,
  tvew_out_if.source   out_o,
  tvew_cfg_if.sink     cfg_i
);

  logic [tvew_pkg::BETA_W-1:0]  beta_q;
  logic                         adv;
  tvew_pkg::in_item_t           item;
  tvew_pkg::stage_t             pipe [tvew_pkg::N_ITER + 1];
  logic [tvew_pkg::W_W-1:0]     weight [tvew_pkg::N_LANE];
  logic [tvew_pkg::SUM_W-1:0]   sum;
  logic                         out_valid;
  logic [tvew_pkg::SUM_W-1:0]   sum_chk;
  logic                         sat_ok;

  // Beta register.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= tvew_pkg::BETA_RST;
    end else if (cfg_i.valid) begin
      beta_q <= cfg_i.beta_q40;
    end
  end

  // The pipeline moves whenever the result register is empty or being taken.
  assign adv        = !out_valid || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    item.pix_center  = in_i.pix_center;
    item.pix_up      = in_i.pix_up;
    item.pix_up_left = in_i.pix_up_left;
    item.pix_left    = in_i.pix_left;
    item.pix_right   = in_i.pix_right;
    item.pix_down    = in_i.pix_down;
    item.at_top      = in_i.at_top;
    item.at_left     = in_i.at_left;
    item.at_right    = in_i.at_right;
    item.at_bottom   = in_i.at_bottom;
  end

  tvew_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .item_i  (item),
    .beta_i  (beta_q),
    .stage_o (pipe[0])
  );

  // Root search, most significant weight bit first.
  for (genvar k = 0; k < tvew_pkg::N_ITER; k++) begin : g_iter
    tvew_isqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .bit_i   (tvew_pkg::B_W'(tvew_pkg::N_ITER - 1 - k)),
      .stage_i (pipe[k]),
      .stage_o (pipe[k+1])
    );
  end

  tvew_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .stage_i  (pipe[tvew_pkg::N_ITER]),
    .valid_o  (out_valid),
    .weight_o (weight),
    .sum_o    (sum)
  );

  assign out_o.valid        = out_valid;
  assign out_o.weight_up    = weight[tvew_pkg::LANE_UP];
  assign out_o.weight_left  = weight[tvew_pkg::LANE_LEFT];
  assign out_o.weight_right = weight[tvew_pkg::LANE_RIGHT];
  assign out_o.weight_down  = weight[tvew_pkg::LANE_DOWN];
  assign out_o.weight_sum   = sum;

  // Terms for the checks on the result channel.
  assign sum_chk = tvew_pkg::SUM_W'(out_o.weight_up) + tvew_pkg::SUM_W'(out_o.weight_left) +
                   tvew_pkg::SUM_W'(out_o.weight_right) + tvew_pkg::SUM_W'(out_o.weight_down);
  assign sat_ok  = (out_o.weight_up <= tvew_pkg::WEIGHT_MAX) &&
                   (out_o.weight_left <= tvew_pkg::WEIGHT_MAX) &&
                   (out_o.weight_right <= tvew_pkg::WEIGHT_MAX) &&
                   (out_o.weight_down <= tvew_pkg::WEIGHT_MAX);

  // The diagonal entry is the sum of the four weights shown with it.
  `ASSERT_IMP(a_sum, out_o.valid, out_o.weight_sum == sum_chk, "weight sum mismatch")
  // No weight passes the saturation level.
  `ASSERT_IMP(a_sat, out_o.valid, sat_ok, "weight above saturation")
  // A stall freezes the item at the last search stage.
  `ASSERT_NXT(a_hold, !adv, $stable(pipe[tvew_pkg::N_ITER]), "search stage moved during a stall")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY = 43;

  typedef struct packed {
    logic [tvew_pkg::W_W-1:0]   up;
    logic [tvew_pkg::W_W-1:0]   left;
    logic [tvew_pkg::W_W-1:0]   right;
    logic [tvew_pkg::W_W-1:0]   down;
    logic [tvew_pkg::SUM_W-1:0] sum;
  } weights_t;

  typedef struct {
    tvew_pkg::in_item_t pix;
    logic               has_exp;
    weights_t           exp;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  tvew_in_if  in_ch ();
  tvew_out_if out_ch ();
  tvew_cfg_if cfg_ch ();

  tv_edge_weight_stencil_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  logic [tvew_pkg::BETA_W-1:0] beta_cur;
  weights_t                    pending_weights[$];
  int                          n_errors;
  int                          n_reported;
  int                          n_items;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Overall limit on run time.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // True when w^2 * S <= 2^80, with S = p * 2^40 + beta.
  function automatic bit weight_fits(logic [tvew_pkg::W_W-1:0] w,
                                     logic [tvew_pkg::P_W-1:0] p,
                                     logic [tvew_pkg::BETA_W-1:0] beta);
    logic [255:0] s;
    logic [255:0] prod;
    s    = ({239'd0, p} << tvew_pkg::FRAC) + {208'd0, beta};
    prod = {215'd0, w} * {215'd0, w} * s;
    return prod <= (256'd1 << 80);
  endfunction

  // Inverse square root by bitwise search, saturated at 2^40.
  function automatic logic [tvew_pkg::W_W-1:0] inv_root(int x, int y,
                                                        logic [tvew_pkg::BETA_W-1:0] beta);
    logic [tvew_pkg::W_W-1:0] w;
    logic [tvew_pkg::W_W-1:0] cand;
    logic [tvew_pkg::P_W-1:0] p;
    p = tvew_pkg::P_W'(x * x + y * y);
    w = '0;
    for (int b = tvew_pkg::FRAC; b >= 0; b--) begin
      cand = w | (tvew_pkg::W_W'(1) << b);
      if (weight_fits(cand, p, beta)) w = cand;
    end
    return (w > tvew_pkg::WEIGHT_MAX) ? tvew_pkg::WEIGHT_MAX : w;
  endfunction

  function automatic int adiff(int a, int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Diffusivity weights for one neighbourhood under the current beta.
  function automatic weights_t stencil_weights(tvew_pkg::in_item_t it,
                                               logic [tvew_pkg::BETA_W-1:0] beta);
    weights_t r;
    int c, u, ul, l, rt, d;
    c = int'(it.pix_center); u = int'(it.pix_up); ul = int'(it.pix_up_left);
    l = int'(it.pix_left); rt = int'(it.pix_right); d = int'(it.pix_down);
    r = '0;
    if (!it.at_top)
      r.up = inv_root(it.at_left ? 0 : adiff(u, ul), adiff(c, u), beta);
    if (!it.at_left)
      r.left = inv_root(adiff(c, l), it.at_top ? 0 : adiff(l, ul), beta);
    if (!it.at_right)
      r.right = inv_root(adiff(c, rt), it.at_top ? 0 : adiff(c, u), beta);
    if (!it.at_bottom)
      r.down = inv_root(it.at_left ? 0 : adiff(c, l), adiff(c, d), beta);
    r.sum = tvew_pkg::SUM_W'(r.up) + tvew_pkg::SUM_W'(r.left) +
            tvew_pkg::SUM_W'(r.right) + tvew_pkg::SUM_W'(r.down);
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic tvew_pkg::in_item_t rand_item();
    tvew_pkg::in_item_t it;
    logic [63:0]        rnd;
    int                 mode;
    rnd = {$urandom, $urandom};
    it = tvew_pkg::in_item_t'(rnd[$bits(tvew_pkg::in_item_t)-1:0]);
    mode = $urandom_range(0, 3);
    // Flat or near-flat patches reach the large weights.
    if (mode == 0) begin
      it.pix_up = it.pix_center; it.pix_up_left = it.pix_center;
      it.pix_left = it.pix_center; it.pix_right = it.pix_center;
      it.pix_down = it.pix_center;
    end else if (mode == 1) begin
      it.pix_up      = it.pix_center ^ tvew_pkg::PIXEL_BITS'($urandom_range(0, 3));
      it.pix_left    = it.pix_center ^ tvew_pkg::PIXEL_BITS'($urandom_range(0, 3));
      it.pix_right   = it.pix_center ^ tvew_pkg::PIXEL_BITS'($urandom_range(0, 3));
      it.pix_down    = it.pix_center ^ tvew_pkg::PIXEL_BITS'($urandom_range(0, 3));
      it.pix_up_left = it.pix_center ^ tvew_pkg::PIXEL_BITS'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 1) == 0) begin
      it.at_top = 1'b0; it.at_left = 1'b0; it.at_right = 1'b0; it.at_bottom = 1'b0;
    end
    return it;
  endfunction

  // Send one item and queue what it should produce. The valid line stays high
  // after the taking edge, so the caller either drives the next item or drops it.
  task automatic send_item(tvew_pkg::in_item_t it);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pix_center  <= it.pix_center;
    in_ch.pix_up      <= it.pix_up;
    in_ch.pix_up_left <= it.pix_up_left;
    in_ch.pix_left    <= it.pix_left;
    in_ch.pix_right   <= it.pix_right;
    in_ch.pix_down    <= it.pix_down;
    in_ch.at_top      <= it.at_top;
    in_ch.at_left     <= it.at_left;
    in_ch.at_right    <= it.at_right;
    in_ch.at_bottom   <= it.at_bottom;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_weights.push_back(stencil_weights(it, beta_cur));
    n_items++;
  endtask

  // Write beta once the pipeline has drained.
  task automatic write_beta(logic [tvew_pkg::BETA_W-1:0] beta);
    in_ch.valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.beta_q40 <= beta;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    beta_cur = beta;
  endtask

  // Random back-pressure on the result side, with short and a few long stalls.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = gap_len();
      if (n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    weights_t got;
    weights_t exp;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.weight_up, out_ch.weight_left, out_ch.weight_right,
              out_ch.weight_down, out_ch.weight_sum};
      if (pending_weights.size() == 0) begin
        n_errors++;
        if (n_reported < 10) begin
          n_reported++;
          $display("unexpected item: %p", got);
        end
      end else begin
        exp = pending_weights.pop_front();
        if (got !== exp) begin
          n_errors++;
          if (n_reported < 10) begin
            n_reported++;
            $display("mismatch: expected %p, got %p", exp, got);
          end
        end
      end
    end
  end

  // Stimulus.
  initial begin
    stim_row_t                   rows[$];
    stim_row_t                   row;
    logic [tvew_pkg::BETA_W-1:0] betas[6];
    tvew_pkg::in_item_t          it;
    weights_t                    pred;
    n_errors = 0; n_reported = 0; n_items = 0;
    beta_cur = tvew_pkg::BETA_RST;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.pix_center, in_ch.pix_up, in_ch.pix_up_left, in_ch.pix_left,
     in_ch.pix_right, in_ch.pix_down} = '0;
    {in_ch.at_top, in_ch.at_left, in_ch.at_right, in_ch.at_bottom} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.beta_q40 = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: flat patch saturates, all borders give zero, extremes.
    row.pix = '{8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 1'b0, 1'b0, 1'b0, 1'b0};
    row.has_exp = 1'b1;
    row.exp = '{tvew_pkg::WEIGHT_MAX, tvew_pkg::WEIGHT_MAX, tvew_pkg::WEIGHT_MAX,
                tvew_pkg::WEIGHT_MAX, tvew_pkg::SUM_W'(tvew_pkg::WEIGHT_MAX) << 2};
    rows.push_back(row);
    row.pix = '{8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1};
    row.exp = '0;
    rows.push_back(row);
    row.pix = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1};
    rows.push_back(row);
    row.has_exp = 1'b0;
    row.pix = '{8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
    rows.push_back(row);
    row.pix = '{8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0};
    rows.push_back(row);
    row.pix = '{8'haa, 8'h55, 8'hff, 8'h00, 8'h01, 8'hfe, 1'b1, 1'b0, 1'b0, 1'b0};
    rows.push_back(row);
    row.pix = '{8'h55, 8'haa, 8'h00, 8'hff, 8'hfe, 8'h01, 1'b0, 1'b1, 1'b0, 1'b0};
    rows.push_back(row);
    row.pix = '{8'h80, 8'h7f, 8'h81, 8'h80, 8'h00, 8'h80, 1'b0, 1'b0, 1'b1, 1'b0};
    rows.push_back(row);
    row.pix = '{8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
    rows.push_back(row);
    row.pix = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0};
    rows.push_back(row);
    row.pix = '{8'hfe, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b1, 1'b1};
    rows.push_back(row);

    foreach (rows[i]) begin
      send_item(rows[i].pix);
      pred = stencil_weights(rows[i].pix, beta_cur);
      if (rows[i].has_exp && pred !== rows[i].exp) begin
        n_errors++;
        if (n_reported < 10) begin
          n_reported++;
          $display("table row %0d: expected %p, predicted %p", i, rows[i].exp, pred);
        end
      end
    end

    // Random part across several beta settings, extremes included.
    betas = '{48'd0, 48'hffff_ffff_ffff, 48'd1 << 40, 48'd1, 48'h0, 48'd12345};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) betas[ph] = tvew_pkg::BETA_W'({$urandom, $urandom});
      write_beta(betas[ph]);
      // Flat patch under this beta: exercises saturation when beta is zero.
      it = '{8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 1'b0, 1'b0, 1'b0, 1'b0};
      send_item(it);
      for (int k = 0; k < 205; k++) send_item(rand_item());
    end

    // Drain and finish.
    in_ch.valid <= 1'b0;
    fork
      while (pending_weights.size() != 0) @(posedge clk_i);
      begin
        repeat (200000) @(posedge clk_i);
        n_errors++;
      end
    join_any
    disable fork;
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0 && pending_weights.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/tvew_pkg.sv
sv/tvew_in_if.sv
sv/tvew_out_if.sv
sv/tvew_cfg_if.sv
sv/tvew_prep.sv
sv/tvew_isqrt_stage.sv
sv/tvew_finish.sv
sv/tv_edge_weight_stencil_unit.sv
sim/tb_top.sv
